// ----- rtl/core/bmrc_pkg.sv -----
// Package for the byte memory register CPU step core.
// Holds opcodes, decode masks, store geometry, status codes and the load command; no dependencies.
`default_nettype none
package bmrc_pkg;
    localparam int MEM_BYTES = 256;
    localparam int NUM_REGS  = 8;
    localparam int AW        = $clog2(MEM_BYTES);
    localparam int RW        = $clog2(NUM_REGS);

    localparam logic [31:0] FIELD_A_MASK = 32'h00E0_0000;
    localparam logic [31:0] FIELD_B_MASK = 32'h001C_0000;
    localparam logic [31:0] FIELD_X_MASK = 32'h001F_FFFF;

    localparam logic [7:0] OP_HLT  = 8'h00;
    localparam logic [7:0] OP_NOP  = 8'h01;
    localparam logic [7:0] OP_ADD  = 8'h02;
    localparam logic [7:0] OP_SUB  = 8'h03;
    localparam logic [7:0] OP_MUL  = 8'h04;
    localparam logic [7:0] OP_DIV  = 8'h05;
    localparam logic [7:0] OP_CMP  = 8'h06;
    localparam logic [7:0] OP_MOVR = 8'h07;
    localparam logic [7:0] OP_AND  = 8'h08;
    localparam logic [7:0] OP_OR   = 8'h09;
    localparam logic [7:0] OP_XOR  = 8'h0A;
    localparam logic [7:0] OP_NOT  = 8'h0B;
    localparam logic [7:0] OP_JE   = 8'h0C;
    localparam logic [7:0] OP_JNE  = 8'h0D;
    localparam logic [7:0] OP_JL   = 8'h0E;
    localparam logic [7:0] OP_JLE  = 8'h0F;
    localparam logic [7:0] OP_JG   = 8'h10;
    localparam logic [7:0] OP_JGE  = 8'h11;
    localparam logic [7:0] OP_JMP  = 8'h12;
    localparam logic [7:0] OP_LD   = 8'h13;
    localparam logic [7:0] OP_ST   = 8'h14;
    localparam logic [7:0] OP_MOVI = 8'h15;
    localparam logic [7:0] OP_ADDI = 8'h16;
    localparam logic [7:0] OP_SUBI = 8'h17;
    localparam logic [7:0] OP_MULI = 8'h18;
    localparam logic [7:0] OP_DIVI = 8'h19;
    localparam logic [7:0] OP_LSH  = 8'h1A;
    localparam logic [7:0] OP_RSH  = 8'h1B;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_DIVZERO = 2'd1;
    localparam logic [1:0] ST_UNKNOWN = 2'd2;

    localparam logic CMD_LOAD = 1'b0;
endpackage
`default_nettype wire

// ----- rtl/core/bmrc_div.sv -----
// Iterative 32-bit unsigned restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the core for div and divi.
`default_nettype none
module bmrc_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [31:0]      o_quotient
);
    logic [32:0] r_rem;
    logic [31:0] r_quo;
    logic [31:0] r_dvs;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [32:0] rem_sh;
    logic [32:0] rem_sub;

    assign rem_sh  = {r_rem[31:0], r_quo[31]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                if (!rem_sub[32]) begin
                    r_rem <= rem_sub;
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd31) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ----- rtl/core/byte_memory_register_cpu_step_core.sv -----
// Top level of the byte memory register CPU step core.
// Depends on bmrc_pkg and bmrc_div.
//
// channel | dir | tvalid/tready          | tdata / tuser
// s_axis  | in  | s_axis_tvalid/tready  | tdata: load_address, load_byte; tuser: cmd
// m_axis  | out | m_axis_tvalid/tready  | tdata: next_pc .. dest_value
//
// A load item writes its byte on accept and goes straight to finish. A step runs accept,
// a 4-byte fetch through the single byte memory read port, two register file reads,
// execute and finish; ld and st add byte-wise load or store states, div/divi a bit-serial
// divider wait. Byte and register entries carry valid bits that reset clears, so no
// clearing pass is needed. Reset is synchronous, active low. A step stays in finish while
// the output register is full; the next item is taken while a result waits in that register.
`default_nettype none
module byte_memory_register_cpu_step_core
    import bmrc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // load_address[7:0], load_byte[15:8]
    input  wire logic        s_axis_tuser,  // cmd
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // next_pc[7:0], halted[8], status[10:9], equal[11], less[12], greater[13],
    // reg_written[14], dest_index[17:15], dest_value[49:18], zero[55:50]
    output logic [55:0]      m_axis_tdata
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FETCH = 4'd1;
    localparam logic [3:0] S_RDA   = 4'd2;
    localparam logic [3:0] S_RDB   = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_LD    = 4'd5;
    localparam logic [3:0] S_ST    = 4'd6;
    localparam logic [3:0] S_DIV   = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]  r_state;
    logic [2:0]  r_cnt;
    logic [7:0]  r_pc;
    logic [7:0]  r_npc;
    logic [2:0]  r_flags;  // bit0 equal, bit1 less, bit2 greater
    logic [31:0] r_word;
    logic [31:0] r_ra;
    logic [31:0] r_res;
    logic        r_wr;
    logic        r_halt;
    logic [1:0]  r_status;

    // byte store with per-entry valid bits
    logic [7:0]  r_bmem [MEM_BYTES];
    logic [MEM_BYTES-1:0] r_bvalid;
    logic [7:0]  r_bq;
    logic        r_bq_v;
    logic [AW-1:0] b_raddr;
    logic [AW-1:0] b_waddr;
    logic [7:0]  b_wdata;
    logic        b_we;
    logic [7:0]  b_data;

    // register file
    logic [31:0] r_rf [NUM_REGS];
    logic [NUM_REGS-1:0] r_rvalid;
    logic [31:0] r_rq;
    logic        r_rq_v;
    logic [RW-1:0] rf_raddr;
    logic [31:0] rf_data;

    logic [7:0]  op;
    logic [RW-1:0] ia;
    logic [RW-1:0] ib;
    logic [31:0] x;
    logic        s_acc;
    logic        out_free;

    logic        div_start;
    logic [31:0] div_dvd;
    logic [31:0] div_dvs;
    logic        div_done;
    logic [31:0] div_q;

    assign op = r_word[31:24];
    assign ia = RW'((r_word & FIELD_A_MASK) >> 21);
    assign ib = RW'((r_word & FIELD_B_MASK) >> 18);
    assign x  = r_word & FIELD_X_MASK;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_acc    = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_axis_tvalid || m_axis_tready;
    assign b_data   = r_bq_v ? r_bq : 8'h00;
    assign rf_data  = r_rq_v ? r_rq : 32'h0;

    always_comb begin
        b_raddr = r_pc + AW'(r_cnt[1:0]);
        if (r_state == S_LD) begin
            b_raddr = x[AW-1:0] + AW'(r_cnt[1:0]);
        end
        rf_raddr = (r_state == S_RDA) ? ia : ib;
        b_we    = 1'b0;
        b_waddr = s_axis_tdata[AW-1:0];
        b_wdata = s_axis_tdata[15:8];
        if (s_acc && s_axis_tuser == CMD_LOAD) begin
            b_we = 1'b1;
        end else if (r_state == S_ST) begin
            b_we    = 1'b1;
            b_waddr = x[AW-1:0] + AW'(r_cnt[1:0]);
            b_wdata = r_ra[8*(3 - r_cnt[1:0]) +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        r_bq   <= r_bmem[b_raddr];
        r_bq_v <= r_bvalid[b_raddr];
        if (b_we) begin
            r_bmem[b_waddr] <= b_wdata;
        end
        r_rq   <= r_rf[rf_raddr];
        r_rq_v <= r_rvalid[rf_raddr];
        if (r_state == S_FIN && out_free && r_wr) begin
            r_rf[ia] <= r_res;
        end
    end

    assign div_dvd = r_ra;
    assign div_dvs = (op == OP_DIV) ? rf_data : x;
    assign div_start = (r_state == S_EXEC) && (op == OP_DIV || op == OP_DIVI)
                       && (div_dvs != 32'h0);

    bmrc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cnt         <= '0;
            r_pc          <= '0;
            r_flags       <= '0;
            r_bvalid      <= '0;
            r_rvalid      <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (r_state == S_FIN && out_free) begin
                m_axis_tvalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                m_axis_tvalid <= 1'b0;
            end
            if (b_we) begin
                r_bvalid[b_waddr] <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    if (s_acc) begin
                        r_wr     <= 1'b0;
                        r_halt   <= 1'b0;
                        r_status <= ST_OK;
                        r_res    <= '0;
                        r_npc    <= r_pc;
                        r_word   <= '0;
                        r_state  <= (s_axis_tuser == CMD_LOAD) ? S_FIN : S_FETCH;
                    end
                end
                S_FETCH: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_word <= {r_word[23:0], b_data};
                    end
                    if (r_cnt == 3'd4) begin
                        r_state <= S_RDA;
                    end
                end
                S_RDA: begin
                    r_state <= S_RDB;
                end
                S_RDB: begin
                    r_ra    <= rf_data;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_cnt   <= '0;
                    r_wr    <= 1'b1;
                    r_npc   <= r_pc + 8'd4;
                    r_state <= S_FIN;
                    unique case (op) inside
                        OP_HLT: begin
                            r_wr <= 1'b0; r_halt <= 1'b1; r_npc <= '0;
                        end
                        OP_NOP: r_wr <= 1'b0;
                        OP_ADD: r_res <= r_ra + rf_data;
                        OP_SUB: r_res <= r_ra - rf_data;
                        OP_MUL: r_res <= 32'(r_ra * rf_data);
                        OP_DIV, OP_DIVI: begin
                            if (div_dvs == 32'h0) begin
                                r_res    <= 32'hFFFF_FFFF;
                                r_status <= ST_DIVZERO;
                            end else begin
                                r_state <= S_DIV;
                            end
                        end
                        OP_CMP: begin
                            r_wr    <= 1'b0;
                            r_flags <= {r_ra > rf_data, r_ra < rf_data, r_ra == rf_data};
                        end
                        OP_MOVR: r_res <= rf_data;
                        OP_AND:  r_res <= r_ra & rf_data;
                        OP_OR:   r_res <= r_ra | rf_data;
                        OP_XOR:  r_res <= r_ra ^ rf_data;
                        OP_NOT:  r_res <= ~rf_data;
                        OP_JE, OP_JNE, OP_JL, OP_JLE, OP_JG, OP_JGE, OP_JMP: begin
                            r_wr <= 1'b0;
                            if ((op == OP_JE  && r_flags[0]) ||
                                (op == OP_JNE && !r_flags[0]) ||
                                (op == OP_JL  && r_flags[1]) ||
                                (op == OP_JLE && (r_flags[1] || r_flags[0])) ||
                                (op == OP_JG  && r_flags[2]) ||
                                (op == OP_JGE && (r_flags[2] || r_flags[0])) ||
                                (op == OP_JMP)) begin
                                r_npc <= x[7:0];
                            end
                        end
                        OP_LD: r_state <= S_LD;
                        OP_ST: begin
                            r_wr    <= 1'b0;
                            r_state <= S_ST;
                        end
                        OP_MOVI: r_res <= x;
                        OP_ADDI: r_res <= r_ra + x;
                        OP_SUBI: r_res <= r_ra - x;
                        OP_MULI: r_res <= 32'(r_ra * x);
                        OP_LSH:  r_res <= (x >= 32'd32) ? 32'h0 : (r_ra << x[4:0]);
                        OP_RSH:  r_res <= (x >= 32'd32) ? 32'h0 : (r_ra >> x[4:0]);
                        default: begin
                            r_wr     <= 1'b0;
                            r_status <= ST_UNKNOWN;
                        end
                    endcase
                end
                S_LD: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt != 3'd0) begin
                        r_res <= {r_res[23:0], b_data};
                    end
                    if (r_cnt == 3'd4) begin
                        r_state <= S_FIN;
                    end
                end
                S_ST: begin
                    r_cnt <= r_cnt + 3'd1;
                    if (r_cnt == 3'd3) begin
                        r_state <= S_FIN;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res   <= div_q;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        if (r_wr) begin
                            r_rvalid[ia] <= 1'b1;
                        end
                        r_pc <= r_npc;
                        m_axis_tdata  <= {6'b0,
                                          r_wr ? r_res : 32'h0,
                                          r_wr ? 3'(ia) : 3'd0,
                                          r_wr,
                                          r_flags[2], r_flags[1], r_flags[0],
                                          r_status, r_halt, r_npc};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire
